@@ design/hpc_pkg.sv @@
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared types, codes and palette helper for the HAM palette colorizer.
// ----------------------------------------------------------------------------
package hpc_pkg;

	localparam int NumColorRegs = 32;
	localparam int ColorAw      = $clog2(NumColorRegs);

	localparam logic [1:0] MODE_PIXEL = 2'd0;
	localparam logic [1:0] MODE_REG   = 2'd1;
	localparam logic [1:0] MODE_LINE  = 2'd2;

	localparam logic [1:0] CTRL_LOAD  = 2'd0;
	localparam logic [1:0] CTRL_BLUE  = 2'd1;
	localparam logic [1:0] CTRL_RED   = 2'd2;
	localparam logic [1:0] CTRL_GREEN = 2'd3;

	localparam logic [7:0] NO_BORDER     = 8'hFF;
	localparam logic [8:0] ADDR_CONTROL  = 9'h100;
	localparam logic [8:0] ADDR_COLOR_LO = 9'h180;
	localparam logic [8:0] ADDR_COLOR_HI = 9'h1BF;
	localparam int         HamBit        = 11;

	localparam logic [7:0] IDX_BLACK = 8'd64;
	localparam logic [7:0] IDX_RED_D = 8'd65;
	localparam logic [7:0] IDX_RED_A = 8'd66;
	localparam logic [7:0] IDX_RED_9 = 8'd67;

	typedef logic [11:0] color_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] border;
		logic [5:0] pf;
		logic [4:0] hidx;
		logic [1:0] ctrl;
		logic       spr;
	} item_t;

	typedef struct packed {
		logic       en;
		logic       ham;
	} ctrl_wr_t;

	function automatic color_t index_color(input logic [7:0] idx, input color_t base);
		color_t c;
		if (idx < 8'd32) begin
			c = base;
		end else if (idx < 8'd64) begin
			c = {1'b0, base[11:9], 1'b0, base[7:5], 1'b0, base[3:1]};
		end else begin
			unique case (idx)
				IDX_RED_D: c = 12'hD00;
				IDX_RED_A: c = 12'hA00;
				IDX_RED_9: c = 12'h900;
				default:   c = 12'h000;
			endcase
		end
		return c;
	endfunction

endpackage

@@ design/hpc_color_mem.sv @@
// ----------------------------------------------------------------------------
// hpc_color_mem
// Color register file: one write port, two registered read ports, valid bits
// so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module hpc_color_mem
	import hpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               we,
	input  logic [ColorAw-1:0] waddr,
	input  color_t             wdata,
	input  logic               re,
	input  logic [ColorAw-1:0] raddr_a,
	input  logic [ColorAw-1:0] raddr_b,
	output color_t             rdata_a,
	output color_t             rdata_b
);

	color_t                  mem [NumColorRegs];
	logic [NumColorRegs-1:0] vld_q;
	color_t                  rd_a_q;
	color_t                  rd_b_q;
	logic                    rv_a_q;
	logic                    rv_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rv_a_q <= 1'b0;
			rv_b_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rv_a_q <= vld_q[raddr_a];
				rv_b_q <= vld_q[raddr_b];
			end
		end
	end

	assign rdata_a = rv_a_q ? rd_a_q : '0;
	assign rdata_b = rv_b_q ? rd_b_q : '0;

endmodule

@@ design/hpc_pixel_logic.sv @@
// ----------------------------------------------------------------------------
// hpc_pixel_logic
// Hold color and HAM flag, pixel color selection and hold update.
// ----------------------------------------------------------------------------
module hpc_pixel_logic
	import hpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ctrl_wr_t ctrl_wr,
	input  logic     advance,
	input  item_t    item_s1,
	input  color_t   rdata_a,
	input  color_t   rdata_b,
	output logic     has_result,
	output color_t   color
);

	color_t hold_q;
	logic   ham_q;
	color_t hold_next;
	logic   border_on;
	logic   ham_pixel;
	color_t pf_color;

	assign border_on = item_s1.border != NO_BORDER;
	assign ham_pixel = !border_on && ham_q;
	assign pf_color  = index_color({2'b00, item_s1.pf}, rdata_a);

	always_comb begin
		unique case (item_s1.ctrl)
			CTRL_LOAD:  hold_next = rdata_b;
			CTRL_BLUE:  hold_next = {hold_q[11:4], item_s1.hidx[3:0]};
			CTRL_RED:   hold_next = {item_s1.hidx[3:0], hold_q[7:0]};
			CTRL_GREEN: hold_next = {hold_q[11:8], item_s1.hidx[3:0], hold_q[3:0]};
			default:    hold_next = hold_q;
		endcase
	end

	always_comb begin
		if (border_on) begin
			color = index_color(item_s1.border, rdata_a);
		end else if (!ham_q) begin
			color = pf_color;
		end else begin
			color = item_s1.spr ? pf_color : hold_next;
		end
	end

	assign has_result = item_s1.mode == MODE_PIXEL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			ham_q  <= 1'b0;
		end else begin
			if (ctrl_wr.en) begin
				ham_q <= ctrl_wr.ham;
			end
			if (advance) begin
				if (item_s1.mode == MODE_LINE) begin
					hold_q <= rdata_b;
				end else if (has_result && ham_pixel) begin
					hold_q <= hold_next;
				end
			end
		end
	end

endmodule

@@ design/ham_palette_colorizer.sv @@
// ----------------------------------------------------------------------------
// ham_palette_colorizer
// An accepted word is registered in stage one (item_s1); a pixel's color is then
// registered in out_color_q, which drives m_tdata, once the output is free.
// Throughput: one word per cycle; a word waits in stage one while m_tready stalls.
// Register writes land at acceptance and are seen by the very next word.
// Reset clears the color valid bits (colors read zero), hold color, HAM flag.
// ----------------------------------------------------------------------------
module ham_palette_colorizer
	import hpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// border_index[7:0], playfield_index[13:8], ham_index[18:14],
	// ham_control[20:19], sprite_visible[21], reg_addr[30:22], reg_value[46:31]
	input  logic [47:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pixel_color[11:0]
	output logic [15:0] m_tdata
);

	item_t              item_in;
	item_t              item_s1;
	logic               s1_valid_q;
	logic               advance;
	logic               accept;
	logic [8:0]         reg_addr;
	logic [15:0]        reg_value;
	logic               color_we;
	ctrl_wr_t           ctrl_wr;
	logic [ColorAw-1:0] raddr_a;
	logic [ColorAw-1:0] raddr_b;
	color_t             rdata_a;
	color_t             rdata_b;
	logic               has_result;
	color_t             color;
	logic               out_valid_q;
	color_t             out_color_q;

	assign item_in.mode   = s_tuser;
	assign item_in.border = s_tdata[7:0];
	assign item_in.pf     = s_tdata[13:8];
	assign item_in.hidx   = s_tdata[18:14];
	assign item_in.ctrl   = s_tdata[20:19];
	assign item_in.spr    = s_tdata[21];
	assign reg_addr       = s_tdata[30:22];
	assign reg_value      = s_tdata[46:31];

	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;
	assign accept   = s_tvalid && s_tready;

	assign color_we = accept && item_in.mode == MODE_REG
		&& reg_addr >= ADDR_COLOR_LO && reg_addr <= ADDR_COLOR_HI;
	assign ctrl_wr.en  = accept && item_in.mode == MODE_REG && reg_addr == ADDR_CONTROL;
	assign ctrl_wr.ham = reg_value[HamBit];

	assign raddr_a = (item_in.border != NO_BORDER) ? item_in.border[ColorAw-1:0]
		: item_in.pf[ColorAw-1:0];
	assign raddr_b = (item_in.mode == MODE_LINE) ? '0 : item_in.hidx[ColorAw-1:0];

	hpc_color_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (color_we),
		.waddr   (reg_addr[ColorAw:1]),
		.wdata   (reg_value[11:0]),
		.re      (accept),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	hpc_pixel_logic u_pix (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl_wr    (ctrl_wr),
		.advance    (advance),
		.item_s1    (item_s1),
		.rdata_a    (rdata_a),
		.rdata_b    (rdata_b),
		.has_result (has_result),
		.color      (color)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
		if (advance && has_result) begin
			out_color_q <= color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance && has_result) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_color_q};

endmodule

@@ tb/hpc_color_checker.sv @@
// ----------------------------------------------------------------------------
// hpc_color_checker
// Watches both streams of the HAM palette colorizer. It tracks the color
// registers, hold color and HAM flag and predicts the color of every accepted
// pixel word. It then compares each output word, in order, with the oldest
// predicted color.
// ----------------------------------------------------------------------------
module hpc_color_checker
	import hpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	output int          mismatches,
	output int          colors_due,
	output int          colors_seen
);

	localparam int ReportLimit = 10;

	color_t bank [NumColorRegs];
	color_t hold_c;
	logic   ham_on;
	color_t colors_due_q [$];
	int     errors;
	int     n_seen;

	function automatic color_t shade(input logic [7:0] idx);
		if (idx < 8'd32)
			return bank[idx[4:0]];
		if (idx < 8'd64)
			return (bank[idx[4:0]] >> 1) & 12'h777;
		case (idx)
			IDX_RED_D: return 12'hD00;
			IDX_RED_A: return 12'hA00;
			IDX_RED_9: return 12'h900;
			default:   return 12'h000;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [7:0]  border;
		logic [5:0]  pf;
		logic [4:0]  hidx;
		logic [1:0]  ctrl;
		logic        spr;
		logic [8:0]  addr;
		logic [15:0] value;
		color_t      c;
		if (!arst_n) begin
			for (int i = 0; i < NumColorRegs; i++)
				bank[i] = '0;
			hold_c = '0;
			ham_on = 1'b0;
			colors_due_q.delete();
			errors = 0;
			n_seen = 0;
			mismatches  <= 0;
			colors_due  <= 0;
			colors_seen <= 0;
		end else begin
			// a color leaving now belongs to an earlier word, so check first
			if (m_tvalid && m_tready) begin
				n_seen++;
				if (colors_due_q.size() == 0) begin
					errors++;
					if (errors <= ReportLimit)
						$display("%0t: color %h with no pixel pending", $realtime, m_tdata);
				end else begin
					c = colors_due_q.pop_front();
					if (m_tdata !== {4'h0, c}) begin
						errors++;
						if (errors <= ReportLimit)
							$display("%0t: color mismatch, expected %h, got %h",
								$realtime, {4'h0, c}, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				border = s_tdata[7:0];
				pf     = s_tdata[13:8];
				hidx   = s_tdata[18:14];
				ctrl   = s_tdata[20:19];
				spr    = s_tdata[21];
				addr   = s_tdata[30:22];
				value  = s_tdata[46:31];
				case (s_tuser)
					MODE_REG: begin
						if (addr == ADDR_CONTROL)
							ham_on = value[HamBit];
						else if (addr >= ADDR_COLOR_LO && addr <= ADDR_COLOR_HI)
							bank[addr[5:1]] = value[11:0];
					end
					MODE_LINE: begin
						hold_c = bank[0];
					end
					MODE_PIXEL: begin
						if (border != NO_BORDER) begin
							c = shade(border);
						end else if (!ham_on) begin
							c = shade({2'b00, pf});
						end else begin
							case (ctrl)
								CTRL_LOAD:  hold_c       = bank[hidx];
								CTRL_BLUE:  hold_c[3:0]  = hidx[3:0];
								CTRL_RED:   hold_c[11:8] = hidx[3:0];
								CTRL_GREEN: hold_c[7:4]  = hidx[3:0];
								default:    hold_c       = hold_c;
							endcase
							c = spr ? shade({2'b00, pf}) : hold_c;
						end
						colors_due_q.push_back(c);
					end
					default: ;
				endcase
			end
			mismatches  <= errors;
			colors_due  <= colors_due_q.size();
			colors_seen <= n_seen;
		end
	end

endmodule

@@ tb/tb_ham_palette_colorizer.sv @@
// ----------------------------------------------------------------------------
// tb_ham_palette_colorizer
// Drives the HAM palette colorizer with a directed set of pixel, register and
// line words, then with random scan lines, palette updates and noise. Both
// sides idle at random, and the output once holds off long enough to stall
// the input. A checker beside the block predicts and compares every color.
// ----------------------------------------------------------------------------
module tb_ham_palette_colorizer
	import hpc_pkg::*;
();

	localparam logic [1:0] MODE_UNUSED     = 2'd3;
	localparam int         WordsRandom     = 1625;
	localparam int         HoldOffCycles   = 300;
	localparam int         HoldOffAfter    = 400;
	localparam int         WatchdogLimit   = 3000;
	localparam int         TailCycles      = 8;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	int   mismatches;
	int   colors_due;
	int   colors_seen;
	int   words_by_mode [4];
	int   words_random;
	logic steady;
	logic hold_off_req;

	ham_palette_colorizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	hpc_color_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.colors_due  (colors_due),
		.colors_seen (colors_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int idle_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [47:0] pack_word(input logic [7:0] border, input logic [5:0] pf,
			input logic [4:0] hidx, input logic [1:0] ctrl, input logic spr,
			input logic [8:0] addr, input logic [15:0] value);
		return {1'b0, value, addr, spr, ctrl, hidx, pf, border};
	endfunction

	function automatic logic [47:0] random_fields();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return {1'b0, r[46:0]};
	endfunction

	// entered and left at a falling edge
	task automatic send_word(input logic [1:0] mode, input logic [47:0] data);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		words_by_mode[mode]++;
		@(negedge clk);
	endtask

	task automatic send_pixel(input logic [7:0] border, input logic [5:0] pf,
			input logic [4:0] hidx, input logic [1:0] ctrl, input logic spr);
		send_word(MODE_PIXEL, pack_word(border, pf, hidx, ctrl, spr,
			9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535))));
	endtask

	task automatic poke_register(input logic [8:0] addr, input logic [15:0] value);
		logic [47:0] d;
		d = random_fields();
		send_word(MODE_REG, pack_word(d[7:0], d[13:8], d[18:14], d[20:19], d[21], addr, value));
	endtask

	// output side
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HoldOffCycles) @(negedge clk);
				hold_off_req = 1'b0;
				m_tready <= 1'b1;
			end else if (steady) begin
				m_tready <= 1'b1;
			end else begin
				stall = idle_len();
				if (stall == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					repeat (stall - 1) @(negedge clk);
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WatchdogLimit) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int  seg;
		int  n;
		int  r;
		logic [8:0] addr;
		logic [7:0] border;
		logic hold_off_done;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = MODE_PIXEL;
		steady       = 1'b0;
		hold_off_req = 1'b0;
		hold_off_done = 1'b0;
		words_random = 0;
		for (int i = 0; i < 4; i++)
			words_by_mode[i] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_pixel(8'd0, 6'd0, 5'd0, CTRL_LOAD, 1'b0);
		poke_register(ADDR_COLOR_LO, 16'hFFFF);
		poke_register(ADDR_COLOR_HI, 16'h1234);   // odd address, lands in color 31
		poke_register(9'h000, 16'hFFFF);
		poke_register(9'h1C0, 16'h0ABC);
		poke_register(9'h1FF, 16'hFFFF);
		send_pixel(8'd31, 6'd0, 5'd0, CTRL_LOAD, 1'b0);
		send_pixel(8'd63, 6'd0, 5'd0, CTRL_LOAD, 1'b0);
		send_pixel(IDX_BLACK, 6'd0, 5'd0, CTRL_LOAD, 1'b0);
		send_pixel(IDX_RED_D, 6'd0, 5'd0, CTRL_LOAD, 1'b0);
		send_pixel(IDX_RED_A, 6'd0, 5'd0, CTRL_LOAD, 1'b0);
		send_pixel(IDX_RED_9, 6'd0, 5'd0, CTRL_LOAD, 1'b0);
		send_pixel(8'd68, 6'd0, 5'd0, CTRL_LOAD, 1'b0);
		send_pixel(8'd254, 6'd0, 5'd0, CTRL_LOAD, 1'b0);
		send_pixel(NO_BORDER, 6'd63, 5'd31, CTRL_GREEN, 1'b1);
		poke_register(ADDR_CONTROL, 16'h0800);
		send_word(MODE_LINE, random_fields());
		send_pixel(NO_BORDER, 6'd0, 5'h1F, CTRL_BLUE, 1'b0);
		send_pixel(NO_BORDER, 6'd0, 5'h15, CTRL_RED, 1'b0);
		send_pixel(NO_BORDER, 6'd0, 5'h0A, CTRL_GREEN, 1'b0);
		send_pixel(NO_BORDER, 6'd63, 5'd31, CTRL_LOAD, 1'b1);  // sprite shown, hold still loads
		send_pixel(NO_BORDER, 6'd0, 5'd0, CTRL_BLUE, 1'b0);
		send_pixel(IDX_RED_D, 6'd0, 5'd0, CTRL_LOAD, 1'b0);    // border wins, hold kept
		send_word(MODE_UNUSED, random_fields());
		poke_register(ADDR_CONTROL, 16'hF7FF);

		while (words_random < WordsRandom) begin
			steady = ($urandom_range(0, 9) == 0);
			if (!hold_off_done && words_random > HoldOffAfter) begin
				hold_off_req  = 1'b1;
				hold_off_done = 1'b1;
			end
			seg = $urandom_range(0, 99);
			if (seg < 70) begin
				send_word(MODE_LINE, random_fields());
				words_random++;
				n = $urandom_range(8, 40);
				repeat (n) begin
					r = $urandom_range(0, 99);
					if (r < 70)
						border = NO_BORDER;
					else if (r < 90)
						border = 8'($urandom_range(0, 67));
					else
						border = 8'($urandom_range(0, 255));
					send_pixel(border, 6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)),
						2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
					words_random++;
				end
			end else if (seg < 90) begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					r = $urandom_range(0, 99);
					if (r < 60)
						addr = ADDR_COLOR_LO + 9'($urandom_range(0, 63));
					else if (r < 75)
						addr = ADDR_CONTROL;
					else if (r < 80)
						addr = '0;
					else
						addr = 9'($urandom_range(0, 511));
					poke_register(addr, 16'($urandom_range(0, 65535)));
					words_random++;
				end
			end else begin
				n = $urandom_range(1, 5);
				repeat (n) begin
					r = $urandom_range(0, 3);
					send_word(r[1:0], random_fields());
					if (r[1:0] != MODE_UNUSED)
						words_random++;
				end
			end
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		while (colors_due != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("Sent %0d pixel, %0d register, %0d line start and %0d unused-mode words;",
			words_by_mode[MODE_PIXEL], words_by_mode[MODE_REG], words_by_mode[MODE_LINE],
			words_by_mode[MODE_UNUSED]);
		$display("checked %0d colors against the prediction, %0d mismatches.",
			colors_seen, mismatches);
		if (mismatches == 0 && colors_due == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
